/* hw/rtl/shtc_pkg.sv */
// ----------------------------------------------------------------------------
// shtc_pkg
// Shared constants, register indexes and control types for the strobe
// heat-time compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package shtc_pkg;

    localparam int STROBE_GROUPS_DEF   = 6;
    localparam int BYTES_PER_GROUP_DEF = 8;

    localparam int DOT_W       = 8;
    localparam int DENSITY_W   = 8;
    localparam int BASE_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int BASE_NS_W   = 26;
    localparam int OUT_GROUP_W = 3;
    localparam int OUT_COUNT_W = 7;
    localparam int PULSE_W     = 28;
    localparam int OUT_DATA_W  = 40;

    // divide by one hundred: drop two bits, then multiply by 2^35 / 25 rounded up
    localparam int                   QUARTER_W   = 32;
    localparam int                   PRE_SHIFT   = 2;
    localparam logic [QUARTER_W-1:0] RECIP_25    = 32'h51EB851F;
    localparam int                   RECIP_SHIFT = 35;

    localparam logic [DENSITY_W-1:0] DENSITY_RST = 8'd64;
    localparam logic [BASE_W-1:0]    BASE_US_RST = 16'd2000;
    localparam logic [9:0]           NS_PER_US   = 10'd1000;
    localparam int                   DOT_COUNT_MAX = 127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DENSITY = 2'd0,
        REG_BASE_US = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic accept;
        logic mul;
        logic add;
        logic scale;
        logic divide;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic group_end;
        logic out_room;
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/shtc_dp.sv */
// ----------------------------------------------------------------------------
// shtc_dp
// Datapath: dot counting per strobe group, pulse arithmetic, divide by one
// hundred through a reciprocal multiply and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module shtc_dp #(
    parameter int STROBE_GROUPS   = shtc_pkg::STROBE_GROUPS_DEF,
    parameter int BYTES_PER_GROUP = shtc_pkg::BYTES_PER_GROUP_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire shtc_pkg::t_cmd                    i_cmd,
    output shtc_pkg::t_status                      o_status,
    input  wire logic [shtc_pkg::DOT_W-1:0]        i_dot_byte,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [shtc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [shtc_pkg::CFG_W-1:0]        i_cfg_wdata,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [shtc_pkg::OUT_GROUP_W-1:0]       o_strobe_group,
    output logic [shtc_pkg::OUT_COUNT_W-1:0]       o_dot_count,
    output logic [shtc_pkg::PULSE_W-1:0]           o_pulse_ns,
    output logic                                   o_line_done
);

    localparam int CNT_W   = $clog2(BYTES_PER_GROUP * 8 + 1);
    localparam int BYTE_W  = (BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1;
    localparam int GRP_W   = (STROBE_GROUPS > 1) ? $clog2(STROBE_GROUPS) : 1;
    localparam int SQ_W    = 2 * CNT_W;
    localparam int SUM_W   = ((shtc_pkg::BASE_NS_W > SQ_W) ? shtc_pkg::BASE_NS_W : SQ_W) + 1;
    localparam int PROD_W  = SUM_W + shtc_pkg::DENSITY_W;
    localparam int CEXT_W  = (CNT_W > shtc_pkg::OUT_COUNT_W) ? CNT_W : shtc_pkg::OUT_COUNT_W;

    function automatic logic [3:0] ones_in_byte(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'b000, b[k]};
        end
        return n;
    endfunction

    logic [shtc_pkg::DENSITY_W-1:0] r_density;
    logic [shtc_pkg::BASE_W-1:0]    r_base_us;
    logic [CNT_W-1:0]               r_acc;
    logic [BYTE_W-1:0]              r_byte_idx;
    logic [GRP_W-1:0]               r_group;
    logic [CNT_W-1:0]               r_count;
    logic [GRP_W-1:0]               r_res_group;
    logic                           r_res_last;
    logic [SQ_W-1:0]                r_sq;
    logic [shtc_pkg::BASE_NS_W-1:0] r_base_ns;
    logic [SUM_W-1:0]               r_sum;
    logic [PROD_W-1:0]              r_prod;
    logic [shtc_pkg::PULSE_W-1:0]   r_quot;
    logic                           r_out_valid;
    logic [shtc_pkg::OUT_GROUP_W-1:0] r_out_group;
    logic [shtc_pkg::OUT_COUNT_W-1:0] r_out_count;
    logic [shtc_pkg::PULSE_W-1:0]   r_out_pulse;
    logic                           r_out_last;

    logic [CNT_W-1:0]               n_total;
    logic                           group_end;
    logic                           last_group;
    logic [shtc_pkg::QUARTER_W-1:0] prod_quarter;
    logic [2*shtc_pkg::QUARTER_W-1:0] recip_prod;
    logic [CEXT_W-1:0]              count_ext;
    logic [GRP_W+2:0]               group_ext;

    assign n_total      = r_acc + CNT_W'(ones_in_byte(i_dot_byte));
    assign group_end    = (r_byte_idx == BYTE_W'(BYTES_PER_GROUP - 1));
    assign last_group   = (r_group == GRP_W'(STROBE_GROUPS - 1));
    // product stays below 2^34, so the quarter fits 32 bits
    assign prod_quarter = shtc_pkg::QUARTER_W'(r_prod >> shtc_pkg::PRE_SHIFT);
    assign recip_prod   = {{shtc_pkg::QUARTER_W{1'b0}}, prod_quarter}
                        * {{shtc_pkg::QUARTER_W{1'b0}}, shtc_pkg::RECIP_25};
    assign count_ext    = CEXT_W'(r_count);
    assign group_ext    = {3'b000, r_res_group};

    assign o_status.group_end = group_end;
    assign o_status.out_room  = !r_out_valid || i_out_ready;

    // control state: configuration, line position, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density   <= shtc_pkg::DENSITY_RST;
            r_base_us   <= shtc_pkg::BASE_US_RST;
            r_acc       <= '0;
            r_byte_idx  <= '0;
            r_group     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (shtc_pkg::t_reg_idx'(i_cfg_index))
                    shtc_pkg::REG_DENSITY: r_density <= i_cfg_wdata[shtc_pkg::DENSITY_W-1:0];
                    shtc_pkg::REG_BASE_US: r_base_us <= i_cfg_wdata[shtc_pkg::BASE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                if (group_end) begin
                    r_acc      <= '0;
                    r_byte_idx <= '0;
                    r_group    <= last_group ? '0 : r_group + GRP_W'(1);
                end else begin
                    r_acc      <= n_total;
                    r_byte_idx <= r_byte_idx + BYTE_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && group_end) begin
            r_count     <= n_total;
            r_res_group <= r_group;
            r_res_last  <= last_group;
        end
        if (i_cmd.mul) begin
            r_sq      <= SQ_W'(r_count) * SQ_W'(r_count);
            r_base_ns <= shtc_pkg::BASE_NS_W'({10'd0, r_base_us} * {16'd0, shtc_pkg::NS_PER_US});
        end
        if (i_cmd.add) begin
            r_sum <= SUM_W'(r_base_ns) + SUM_W'(r_sq);
        end
        if (i_cmd.scale) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(r_density);
        end
        if (i_cmd.divide) begin
            r_quot <= recip_prod[shtc_pkg::RECIP_SHIFT +: shtc_pkg::PULSE_W];
        end
        if (i_cmd.out_load) begin
            r_out_group <= group_ext[2:0];
            r_out_count <= (count_ext > CEXT_W'(shtc_pkg::DOT_COUNT_MAX))
                         ? shtc_pkg::OUT_COUNT_W'(shtc_pkg::DOT_COUNT_MAX)
                         : count_ext[shtc_pkg::OUT_COUNT_W-1:0];
            r_out_pulse <= r_quot;
            r_out_last  <= r_res_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_strobe_group = r_out_group;
    assign o_dot_count    = r_out_count;
    assign o_pulse_ns     = r_out_pulse;
    assign o_line_done    = r_out_last;

    a_no_accept_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.divide |-> !i_cmd.accept)
        else $error("dot byte taken during divide");

    a_group_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_group < GRP_W'(STROBE_GROUPS)) || (STROBE_GROUPS >= (1 << GRP_W)))
        else $error("strobe group index past end of line");

    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

endmodule

`default_nettype wire

/* hw/rtl/shtc_ctrl.sv */
// ----------------------------------------------------------------------------
// shtc_ctrl
// Controller: accepts dot bytes and sequences multiply, add, scale,
// reciprocal divide and result load for each completed strobe group.
// ----------------------------------------------------------------------------
`default_nettype none

module shtc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire shtc_pkg::t_status i_status,
    output shtc_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_SCALE,
        ST_DIV,
        ST_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = i_in_valid && r_in_ready;
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.add      = (r_state == ST_ADD);
        o_cmd.scale    = (r_state == ST_SCALE);
        o_cmd.divide   = (r_state == ST_DIV);
        o_cmd.out_load = (r_state == ST_LOAD) && i_status.out_room;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (o_cmd.accept && i_status.group_end) n_state = ST_MUL;
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_DIV;
            ST_DIV:   n_state = ST_LOAD;
            ST_LOAD:  if (i_status.out_room) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == ST_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

    a_stall_after_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.group_end) |=> !r_in_ready)
        else $error("input taken while a group is being computed");

    a_divide_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.divide |=> (r_state == ST_LOAD))
        else $error("divide not followed by result load");

    a_ready_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_in_ready)
        else $error("input not resumed after result load");

endmodule

`default_nettype wire

/* hw/rtl/strobe_heat_time_compensation.sv */
// ----------------------------------------------------------------------------
// strobe_heat_time_compensation
// Counts heated dots per strobe group of a printhead line and gives each
// group's compensated, density-scaled strobe pulse length in nanoseconds.
// ----------------------------------------------------------------------------
// mid-group dot bytes: one per cycle, no result
// group-end byte: result passes multiply, add, density scale, reciprocal divide by
//   one hundred and load states in order, the load waiting for output room
// input stalls from the group-end byte until the result enters the output register
// synchronous active-low reset: line position at start, density 64, base 2000 us
`default_nettype none

module strobe_heat_time_compensation #(
    parameter int STROBE_GROUPS   = shtc_pkg::STROBE_GROUPS_DEF,
    parameter int BYTES_PER_GROUP = shtc_pkg::BYTES_PER_GROUP_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // dot_byte[7:0]
    input  wire logic [shtc_pkg::DOT_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // strobe_group[2:0], dot_count[9:3], pulse_ns[37:10], zero[39:38]
    output logic [shtc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [shtc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [shtc_pkg::CFG_W-1:0]      i_cfg_wdata
);

    shtc_pkg::t_cmd    cmd;
    shtc_pkg::t_status status;

    logic [shtc_pkg::OUT_GROUP_W-1:0] strobe_group;
    logic [shtc_pkg::OUT_COUNT_W-1:0] dot_count;
    logic [shtc_pkg::PULSE_W-1:0]     pulse_ns;

    shtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    shtc_dp #(
        .STROBE_GROUPS   (STROBE_GROUPS),
        .BYTES_PER_GROUP (BYTES_PER_GROUP)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_dot_byte     (s_axis_tdata),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_strobe_group (strobe_group),
        .o_dot_count    (dot_count),
        .o_pulse_ns     (pulse_ns),
        .o_line_done    (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, pulse_ns, dot_count, strobe_group};

endmodule

`default_nettype wire

/* tb/strobe_heat_time_compensation_tb.sv */
// ----------------------------------------------------------------------------
// strobe_heat_time_compensation_tb
// Streams dot bytes into the strobe compensation block and checks each group's
// index, dot count, pulse length and line-end flag against a bit-exact
// prediction. Density and base pulse settings are changed between phases
// while the block is idle, extremes included. Both stream sides idle at
// random in changing proportions, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
`default_nettype none

module strobe_heat_time_compensation_tb;

    localparam int GROUPS        = shtc_pkg::STROBE_GROUPS_DEF;
    localparam int GROUP_BYTES   = shtc_pkg::BYTES_PER_GROUP_DEF;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 80;

    typedef struct {
        logic [shtc_pkg::OUT_GROUP_W-1:0] group;
        logic [shtc_pkg::OUT_COUNT_W-1:0] dots;
        logic [shtc_pkg::PULSE_W-1:0]     pulse;
        logic                             line_end;
    } t_strobe_pulse;

    class strobe_pulse_tracker;
        logic [shtc_pkg::DENSITY_W-1:0] density;
        logic [shtc_pkg::BASE_W-1:0]    base_us;
        int unsigned          byte_pos;
        int unsigned          group_dots;
        t_strobe_pulse        pulses_due[$];
        int unsigned          mismatches;
        int unsigned          groups_checked;
        int unsigned          lines_checked;

        function new();
            density        = shtc_pkg::DENSITY_RST;
            base_us        = shtc_pkg::BASE_US_RST;
            byte_pos       = 0;
            group_dots     = 0;
            mismatches     = 0;
            groups_checked = 0;
            lines_checked  = 0;
        endfunction

        function void write_reg(shtc_pkg::t_reg_idx idx, logic [shtc_pkg::CFG_W-1:0] value);
            if (idx == shtc_pkg::REG_DENSITY)
                density = value[shtc_pkg::DENSITY_W-1:0];
            else if (idx == shtc_pkg::REG_BASE_US)
                base_us = value[shtc_pkg::BASE_W-1:0];
        endfunction

        function logic [shtc_pkg::PULSE_W-1:0] pulse_length_ns(int unsigned dots);
            longint unsigned heat;
            heat = base_us;
            heat = heat * 1000 + dots * dots;
            heat = heat * density / 100;
            return heat[shtc_pkg::PULSE_W-1:0];
        endfunction

        function void take_dot_byte(logic [shtc_pkg::DOT_W-1:0] dot);
            t_strobe_pulse p;
            int unsigned   group;
            group_dots += $countones(dot);
            group = byte_pos / GROUP_BYTES;
            if (byte_pos % GROUP_BYTES != GROUP_BYTES - 1) begin
                byte_pos++;
            end else begin
                p.group    = group[shtc_pkg::OUT_GROUP_W-1:0];
                p.dots     = (group_dots > shtc_pkg::DOT_COUNT_MAX)
                           ? shtc_pkg::OUT_COUNT_W'(shtc_pkg::DOT_COUNT_MAX)
                           : group_dots[shtc_pkg::OUT_COUNT_W-1:0];
                p.pulse    = pulse_length_ns(group_dots);
                p.line_end = (group >= GROUPS - 1);
                pulses_due.push_back(p);
                group_dots = 0;
                byte_pos   = p.line_end ? 0 : byte_pos + 1;
            end
        endfunction

        function void check_pulse(logic [shtc_pkg::OUT_DATA_W-1:0] data, logic last);
            t_strobe_pulse p;
            if (pulses_due.size() == 0) begin
                $error("unexpected result transaction: data %h last %b", data, last);
                mismatches++;
                return;
            end
            p = pulses_due.pop_front();
            groups_checked++;
            if (p.line_end)
                lines_checked++;
            if (data[2:0] !== p.group) begin
                $error("strobe_group: expected %0d, got %0d", p.group, data[2:0]);
                mismatches++;
            end
            if (data[9:3] !== p.dots) begin
                $error("dot_count: expected %0d, got %0d", p.dots, data[9:3]);
                mismatches++;
            end
            if (data[37:10] !== p.pulse) begin
                $error("pulse_ns: expected %0d, got %0d", p.pulse, data[37:10]);
                mismatches++;
            end
            if (data[39:38] !== 2'b00) begin
                $error("tdata padding: expected 0, got %0d", data[39:38]);
                mismatches++;
            end
            if (last !== p.line_end) begin
                $error("line_done: expected %0d, got %0d", p.line_end, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic [shtc_pkg::DOT_W-1:0]           s_axis_tdata;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    logic [shtc_pkg::OUT_DATA_W-1:0]      m_axis_tdata;
    logic                                 m_axis_tlast;
    logic                                 i_cfg_wr_en;
    logic [shtc_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [shtc_pkg::CFG_W-1:0]           i_cfg_wdata;

    strobe_pulse_tracker tracker;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned bytes_sent;
    int unsigned settings_used;
    int unsigned stall_cycles;

    strobe_heat_time_compensation u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_pulse(m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_dot_byte(input logic [shtc_pkg::DOT_W-1:0] dot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = dot;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_dot_byte(dot);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained(input int unsigned extra);
        s_axis_tvalid = 1'b0;
        while (tracker.pulses_due.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input shtc_pkg::t_reg_idx idx,
                             input logic [shtc_pkg::CFG_W-1:0] value);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        tracker.write_reg(idx, value);
    endtask

    function automatic logic [shtc_pkg::DOT_W-1:0] random_dot_byte();
        case ($urandom_range(0, 9))
            0: return 8'hFF;
            1: return 8'h00;
            2: return 8'h01 << $urandom_range(0, 7);
            3: return ~(8'h01 << $urandom_range(0, 7));
            default: return shtc_pkg::DOT_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [shtc_pkg::DENSITY_W-1:0] density;
        logic [shtc_pkg::BASE_W-1:0]    base_us;
        logic [7:0]                     upper;

        tracker       = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        send_idle_pct = 23;
        recv_idle_pct = 60;
        bytes_sent    = 0;
        settings_used = 1;
        stall_cycles  = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: a full group, an empty group, one dot per byte
        for (int i = 0; i < GROUP_BYTES; i++) send_dot_byte(8'hFF);
        for (int i = 0; i < GROUP_BYTES; i++) send_dot_byte(8'h00);
        for (int i = 0; i < GROUP_BYTES; i++) send_dot_byte(8'h01 << i);

        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct = (p < 2) ? 23 : (p < 4) ? 60 : 0;
            recv_idle_pct = (p < 2) ? 60 : (p < 4) ? 23 : 0;
            case (p)
                0: begin
                    density = 8'd255;
                    base_us = 16'hFFFF;
                    upper   = 8'hFF;
                end
                1: begin
                    density = 8'd0;
                    base_us = shtc_pkg::BASE_W'($urandom);
                    upper   = 8'h00;
                end
                2: begin
                    density = shtc_pkg::DENSITY_W'($urandom);
                    base_us = 16'h0000;
                    upper   = 8'($urandom);
                end
                3: begin
                    density = 8'd100;
                    base_us = shtc_pkg::BASE_W'($urandom);
                    upper   = 8'($urandom);
                end
                4: begin
                    density = shtc_pkg::DENSITY_W'($urandom);
                    base_us = shtc_pkg::BASE_W'($urandom);
                    upper   = 8'($urandom);
                end
                default: begin
                    density = 8'd1;
                    base_us = 16'hFFFF;
                    upper   = 8'($urandom);
                end
            endcase
            hold_until_drained(SETTLE_CYCLES);
            if (p % 2 == 0) begin
                write_reg(shtc_pkg::REG_BASE_US, base_us);
                write_reg(shtc_pkg::REG_DENSITY, {upper, density});
            end else begin
                write_reg(shtc_pkg::REG_DENSITY, {upper, density});
                write_reg(shtc_pkg::REG_BASE_US, base_us);
            end
            settings_used++;
            for (int i = 0; i < PHASE_BYTES; i++) begin
                send_dot_byte(random_dot_byte());
                if ((p == 0 && i == 40) || $urandom_range(0, 49) == 0)
                    hold_until_drained(0);
            end
        end

        hold_until_drained(SETTLE_CYCLES);

        $display("covered %0d dot bytes, %0d strobe groups checked over %0d full lines",
                 bytes_sent, tracker.groups_checked, tracker.lines_checked);
        $display("%0d density/base settings, zero and full-scale values included",
                 settings_used);
        if (tracker.mismatches == 0 && tracker.pulses_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* strobe_heat_time_compensation.f */
hw/rtl/shtc_pkg.sv
hw/rtl/shtc_dp.sv
hw/rtl/shtc_ctrl.sv
hw/rtl/strobe_heat_time_compensation.sv
tb/strobe_heat_time_compensation_tb.sv
